// ----- rtl/preemptive_priority_scheduler_macros.svh -----
// assertion macros shared by the scheduler rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PPS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pps assertion failed");

// next-cycle implication
`define PPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pps assertion failed");

`else

`define PPS_ASSERT_NOW(label, clk, rstn, ante, cons)
`define PPS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/pps_pkg.sv -----
// types and fixed widths for the preemptive priority scheduler
// no dependencies
package pps_pkg;

    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRI_W   = 8;
    localparam int TICK_W  = 24;
    localparam int TOT_W   = 28;
    localparam int OIDX_W  = 4;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SEARCH,
        S_UPDATE,
        S_FETCH,
        S_CALC,
        S_SEND
    } pps_state_t;

    typedef struct packed {
        logic load;
        logic search;
        logic update;
        logic fetch;
        logic calc;
        logic send;
    } pps_cmd_t;

    typedef struct packed {
        logic closes;
        logic sim_done;
        logic out_last;
    } pps_sts_t;

endpackage

// ----- rtl/pps_ctrl.sv -----
// control state machine of the scheduler
// depends on pps_pkg and the assertion macros header
`include "preemptive_priority_scheduler_macros.svh"

module pps_ctrl import pps_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  pps_sts_t sts,
    output pps_cmd_t cmd
);

    pps_state_t state_reg;
    pps_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_valid && sts.closes) begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                state_next = sts.sim_done ? S_FETCH : S_SEARCH;
            end
            S_FETCH: begin
                state_next = S_CALC;
            end
            S_CALC: begin
                state_next = S_SEND;
            end
            S_SEND: begin
                if (m_ready) begin
                    state_next = sts.out_last ? S_LOAD : S_FETCH;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_SEARCH: begin
                cmd.search = 1'b1;
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
            end
            S_FETCH: begin
                cmd.fetch = 1'b1;
            end
            S_CALC: begin
                cmd.calc = 1'b1;
            end
            S_SEND: begin
                m_valid  = 1'b1;
                cmd.send = m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `PPS_ASSERT_NOW(a_no_overlap, aclk, aresetn, 1'b1, !(s_ready && m_valid))
    `PPS_ASSERT_NEXT(a_done_to_fetch, aclk, aresetn, cmd.update && sts.sim_done, cmd.fetch)
    `PPS_ASSERT_NEXT(a_last_to_load, aclk, aresetn, m_valid && m_ready && sts.out_last, s_ready)

endmodule

// ----- rtl/pps_dp.sv -----
// datapath of the scheduler: process cells, pick tree, tick and result stage
// depends on pps_pkg and the assertion macros header
`include "preemptive_priority_scheduler_macros.svh"

module pps_dp import pps_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pps_cmd_t             cmd,
    output pps_sts_t             sts,
    input  logic [ARR_W-1:0]     s_arrival_time,
    input  logic [BURST_W-1:0]   s_burst_length,
    input  logic [PRI_W-1:0]     s_priority_level,
    input  logic                 s_last_process,
    output logic [OIDX_W-1:0]    m_process_index,
    output logic [TICK_W-1:0]    m_waiting_time,
    output logic [TICK_W-1:0]    m_turnaround_time,
    output logic [TOT_W-1:0]     m_total_waiting,
    output logic [TOT_W-1:0]     m_total_turnaround,
    output logic                 m_last_result
);

    localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int LEAVES = 1 << IDX_W;
    localparam int NODES  = 2 * LEAVES - 1;

    // per-process cells
    logic [ARR_W-1:0]   arrival_reg [MAX_PROCS];
    logic [BURST_W-1:0] burst_reg   [MAX_PROCS];
    logic [BURST_W-1:0] remain_reg  [MAX_PROCS];
    logic [PRI_W-1:0]   prio_reg    [MAX_PROCS];
    logic [TICK_W-1:0]  finish_reg  [MAX_PROCS];

    logic [IDX_W-1:0]   count_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   left_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               pick_v_reg;
    logic [IDX_W-1:0]   pick_idx_reg;
    logic               pick_fin_reg;
    logic [TOT_W-1:0]   tw_reg;
    logic [TOT_W-1:0]   tt_reg;

    logic [TICK_W-1:0]  turn_reg;
    logic [BURST_W-1:0] burst_sel_reg;
    logic [OIDX_W-1:0]  m_index_reg;
    logic [TICK_W-1:0]  m_wait_reg;
    logic [TICK_W-1:0]  m_turn_reg;
    logic [TOT_W-1:0]   m_tw_reg;
    logic [TOT_W-1:0]   m_tt_reg;
    logic               m_last_reg;

    logic [CNT_W-1:0]   count_plus1;
    logic [BURST_W-1:0] burst_fix;
    logic [TICK_W-1:0]  tick_plus1;
    logic [TICK_W-1:0]  wait_val;
    logic [TOT_W-1:0]   tw_sum;
    logic [TOT_W-1:0]   tt_sum;
    logic [IDX_W+OIDX_W-1:0] idx_wide;

    // pick tree, heap order, leaves at LEAVES-1
    logic               node_v   [NODES];
    logic [PRI_W-1:0]   node_pri [NODES];
    logic [IDX_W-1:0]   node_idx [NODES];
    logic               node_fin [NODES];

    assign count_plus1 = CNT_W'(count_reg) + CNT_W'(1);
    assign burst_fix   = (s_burst_length == '0) ? BURST_W'(1) : s_burst_length;
    assign tick_plus1  = tick_reg + TICK_W'(1);
    assign wait_val    = turn_reg - TICK_W'(burst_sel_reg);
    assign tw_sum      = tw_reg + TOT_W'(wait_val);
    assign tt_sum      = tt_reg + TOT_W'(turn_reg);
    assign idx_wide    = (IDX_W + OIDX_W)'(out_idx_reg);

    assign sts.closes   = s_last_process || (count_plus1 == CNT_W'(MAX_PROCS));
    assign sts.sim_done = pick_v_reg && pick_fin_reg && (left_reg == CNT_W'(1));
    assign sts.out_last = (CNT_W'(out_idx_reg) + CNT_W'(1)) == n_reg;

    always_comb begin
        for (int i = 0; i < LEAVES; i++) begin
            node_v[LEAVES-1+i]   = 1'b0;
            node_pri[LEAVES-1+i] = '0;
            node_idx[LEAVES-1+i] = IDX_W'(i);
            node_fin[LEAVES-1+i] = 1'b0;
        end
        for (int i = 0; i < MAX_PROCS; i++) begin
            node_v[LEAVES-1+i]   = (CNT_W'(i) < n_reg) && (remain_reg[i] != '0)
                                   && (TICK_W'(arrival_reg[i]) <= tick_reg);
            node_pri[LEAVES-1+i] = prio_reg[i];
            node_fin[LEAVES-1+i] = remain_reg[i] == BURST_W'(1);
        end
        // right child wins when the left is invalid or on a strictly smaller priority
        for (int j = LEAVES - 2; j >= 0; j--) begin
            if (node_v[2*j+2] && (!node_v[2*j+1] || node_pri[2*j+2] < node_pri[2*j+1])) begin
                node_v[j]   = node_v[2*j+2];
                node_pri[j] = node_pri[2*j+2];
                node_idx[j] = node_idx[2*j+2];
                node_fin[j] = node_fin[2*j+2];
            end else begin
                node_v[j]   = node_v[2*j+1];
                node_pri[j] = node_pri[2*j+1];
                node_idx[j] = node_idx[2*j+1];
                node_fin[j] = node_fin[2*j+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_PROCS; i++) begin
            if (cmd.load && count_reg == IDX_W'(i)) begin
                arrival_reg[i] <= s_arrival_time;
                burst_reg[i]   <= burst_fix;
                remain_reg[i]  <= burst_fix;
                prio_reg[i]    <= s_priority_level;
            end else if (cmd.update && pick_v_reg && pick_idx_reg == IDX_W'(i)) begin
                remain_reg[i] <= remain_reg[i] - BURST_W'(1);
                if (pick_fin_reg) begin
                    finish_reg[i] <= tick_plus1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            n_reg        <= '0;
            left_reg     <= '0;
            tick_reg     <= '0;
            out_idx_reg  <= '0;
            pick_v_reg   <= 1'b0;
            pick_idx_reg <= '0;
            pick_fin_reg <= 1'b0;
            tw_reg       <= '0;
            tt_reg       <= '0;
        end else begin
            if (cmd.load) begin
                if (sts.closes) begin
                    count_reg   <= '0;
                    n_reg       <= count_plus1;
                    left_reg    <= count_plus1;
                    tick_reg    <= '0;
                    tw_reg      <= '0;
                    tt_reg      <= '0;
                    out_idx_reg <= '0;
                end else begin
                    count_reg <= count_reg + IDX_W'(1);
                end
            end
            if (cmd.search) begin
                pick_v_reg   <= node_v[0];
                pick_idx_reg <= node_idx[0];
                pick_fin_reg <= node_fin[0];
            end
            if (cmd.update) begin
                tick_reg <= tick_plus1;
                if (pick_v_reg && pick_fin_reg) begin
                    left_reg <= left_reg - CNT_W'(1);
                end
            end
            if (cmd.calc) begin
                tw_reg <= tw_sum;
                tt_reg <= tt_sum;
            end
            if (cmd.send) begin
                out_idx_reg <= out_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            turn_reg      <= finish_reg[out_idx_reg] - TICK_W'(arrival_reg[out_idx_reg]);
            burst_sel_reg <= burst_reg[out_idx_reg];
        end
        if (cmd.calc) begin
            m_index_reg <= idx_wide[OIDX_W-1:0];
            m_wait_reg  <= wait_val;
            m_turn_reg  <= turn_reg;
            m_tw_reg    <= sts.out_last ? tw_sum : '0;
            m_tt_reg    <= sts.out_last ? tt_sum : '0;
            m_last_reg  <= sts.out_last;
        end
    end

    assign m_process_index    = m_index_reg;
    assign m_waiting_time     = m_wait_reg;
    assign m_turnaround_time  = m_turn_reg;
    assign m_total_waiting    = m_tw_reg;
    assign m_total_turnaround = m_tt_reg;
    assign m_last_result      = m_last_reg;

    `PPS_ASSERT_NOW(a_left_in_range, aclk, aresetn, 1'b1, left_reg <= n_reg)
    `PPS_ASSERT_NOW(a_pick_loaded, aclk, aresetn, cmd.update && pick_v_reg,
        CNT_W'(pick_idx_reg) < n_reg)
    `PPS_ASSERT_NEXT(a_tick_no_wrap, aclk, aresetn, cmd.update, tick_reg != '0)

endmodule

// ----- rtl/preemptive_priority_scheduler.sv -----
// top level of the preemptive priority scheduler
// depends on pps_pkg, pps_ctrl and pps_dp
//
// usage: load up to MAX_PROCS processes over the s_ channel, one item each
// (arrival tick, burst length, priority). s_last_process closes the set; the
// MAX_PROCS-th item closes it as well. a burst of zero counts as one tick.
// after the set closes the block simulates preemptive priority scheduling
// and then returns one m_ item per process, in load order, with the totals
// and m_last_result on the final one.
// loading items are accepted back to back. the simulation runs a pick-tree
// search, then a cell update, for each tick until the last process
// finishes. each result goes through fetch, compute and present, and waits
// while the receiver holds m_ready low; s_ready stays low from set close
// until the last result is taken.
// reset: aresetn clears the fill count and tick and returns to loading.
// a stalled result holds its payload and m_valid until it is taken.
module preemptive_priority_scheduler import pps_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ARR_W-1:0]     s_arrival_time,
    input  logic [BURST_W-1:0]   s_burst_length,
    input  logic [PRI_W-1:0]     s_priority_level,
    input  logic                 s_last_process,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OIDX_W-1:0]    m_process_index,
    output logic [TICK_W-1:0]    m_waiting_time,
    output logic [TICK_W-1:0]    m_turnaround_time,
    output logic [TOT_W-1:0]     m_total_waiting,
    output logic [TOT_W-1:0]     m_total_turnaround,
    output logic                 m_last_result
);

    // command and status between controller and datapath
    pps_cmd_t cmd;
    pps_sts_t sts;

    pps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // cells, pick tree, tick counter and result registers
    pps_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_arrival_time     (s_arrival_time),
        .s_burst_length     (s_burst_length),
        .s_priority_level   (s_priority_level),
        .s_last_process     (s_last_process),
        .m_process_index    (m_process_index),
        .m_waiting_time     (m_waiting_time),
        .m_turnaround_time  (m_turnaround_time),
        .m_total_waiting    (m_total_waiting),
        .m_total_turnaround (m_total_turnaround),
        .m_last_result      (m_last_result)
    );

endmodule

// ----- tb/sv/tb_preemptive_priority_scheduler.sv -----
// self-checking testbench for preemptive_priority_scheduler: process sets in, per-process
// waiting and turnaround times out, checked against a behavioral scheduler in this file
// depends on pps_pkg and the scheduler rtl
module tb_preemptive_priority_scheduler;
    import pps_pkg::*;

    localparam int MAX_PROCS = 16;
    localparam int RANDOM_ITEMS = 196;
    localparam longint unsigned NO_ARRIVAL = 64'hFFFF_FFFF_FFFF_FFFF;

    // one reported process, as seen on the m_ channel
    typedef struct packed {
        logic [OIDX_W-1:0] index;
        logic [TICK_W-1:0] waited;
        logic [TICK_W-1:0] tat;
        logic [TOT_W-1:0]  tot_wait;
        logic [TOT_W-1:0]  tot_tat;
        logic              last;
    } proc_result_t;

    // one row of directed stimulus; typed rows carry their answer for a one-process set
    typedef struct packed {
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] burst;
        logic [PRI_W-1:0]   prio;
        logic               last;
        logic               typed;
        logic [TICK_W-1:0]  exp_wait;
        logic [TICK_W-1:0]  exp_tat;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [ARR_W-1:0]   s_arrival_time = '0;
    logic [BURST_W-1:0] s_burst_length = '0;
    logic [PRI_W-1:0]   s_priority_level = '0;
    logic               s_last_process = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [OIDX_W-1:0]  m_process_index;
    logic [TICK_W-1:0]  m_waiting_time;
    logic [TICK_W-1:0]  m_turnaround_time;
    logic [TOT_W-1:0]   m_total_waiting;
    logic [TOT_W-1:0]   m_total_turnaround;
    logic               m_last_result;

    // scheduler image kept by the testbench
    logic [ARR_W-1:0] ps_arrival [MAX_PROCS];
    int unsigned      ps_remaining [MAX_PROCS];
    int unsigned      ps_prio [MAX_PROCS];
    longint unsigned  ps_ready_at [MAX_PROCS];
    int unsigned      ps_waited [MAX_PROCS];
    int unsigned      ps_tat [MAX_PROCS];
    int unsigned      ps_count = 0;
    proc_result_t     ps_report [MAX_PROCS];

    proc_result_t proc_results_q [$];
    int           mismatches = 0;
    logic         calm = 1'b0;      // no idling on either side while set

    // directed part: extremes, zero burst, preemption, idle gap, ties, full store
    stim_row_t dir_rows [24] = '{
        // first set after reset, smallest burst
        '{16'd0,     16'd1,     8'd0,    1'b1, 1'b1, 24'd0, 24'd1},
        // latest arrival and longest burst, idles until it arrives
        '{16'hFFFF,  16'hFFFF,  8'hFF,   1'b1, 1'b1, 24'd0, 24'd65535},
        // zero burst runs for a single tick
        '{16'd5,     16'd0,     8'd7,    1'b1, 1'b1, 24'd0, 24'd1},
        // nested preemption by ever more urgent arrivals
        '{16'd0,     16'd10,    8'd5,    1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd2,     16'd3,     8'd1,    1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd4,     16'd2,     8'd0,    1'b1, 1'b0, 24'd0, 24'd0},
        // idle ticks inside a set
        '{16'd0,     16'd2,     8'd1,    1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd20,    16'd3,     8'd0,    1'b1, 1'b0, 24'd0, 24'd0},
        // sixteen items with no last flag: the full store closes the set
        '{16'd0,     16'd3,     8'd4,    1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd0,     16'd3,     8'd4,    1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd1,     16'd0,     8'hAA,   1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd2,     16'd5,     8'h55,   1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd3,     16'd2,     8'd4,    1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd3,     16'd2,     8'd4,    1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd6,     16'd1,     8'h0F,   1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd8,     16'd4,     8'hF0,   1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd8,     16'd4,     8'h01,   1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd10,    16'd2,     8'h80,   1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd12,    16'd3,     8'h7F,   1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd15,    16'd1,     8'h00,   1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd20,    16'd2,     8'hFE,   1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd21,    16'd6,     8'h04,   1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd25,    16'd1,     8'h33,   1'b0, 1'b0, 24'd0, 24'd0},
        '{16'd30,    16'd2,     8'hCC,   1'b0, 1'b0, 24'd0, 24'd0}
    };

    preemptive_priority_scheduler #(
        .MAX_PROCS(MAX_PROCS)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_arrival_time     (s_arrival_time),
        .s_burst_length     (s_burst_length),
        .s_priority_level   (s_priority_level),
        .s_last_process     (s_last_process),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_process_index    (m_process_index),
        .m_waiting_time     (m_waiting_time),
        .m_turnaround_time  (m_turnaround_time),
        .m_total_waiting    (m_total_waiting),
        .m_total_turnaround (m_total_turnaround),
        .m_last_result      (m_last_result)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // store one process; once the set closes, run the schedule in spans between
    // arrivals and fill ps_report, returning how many results the set produces
    function automatic int accept_process(input logic [ARR_W-1:0] arr,
                                          input logic [BURST_W-1:0] burst,
                                          input logic [PRI_W-1:0] prio,
                                          input logic last_in);
        int unsigned     slot;
        int unsigned     n;
        int unsigned     unfinished;
        int              pick;
        longint unsigned now;
        longint unsigned next_arr;
        longint unsigned span;
        logic [TOT_W-1:0] sum_wait;
        logic [TOT_W-1:0] sum_tat;
        slot = (ps_count >= MAX_PROCS) ? MAX_PROCS - 1 : ps_count;
        ps_arrival[slot]   = arr;
        ps_remaining[slot] = (burst == '0) ? 1 : 32'(burst);  // zero burst counts as one tick
        ps_prio[slot]      = 32'(prio);
        ps_ready_at[slot]  = 64'(arr);
        ps_waited[slot]    = 0;
        ps_tat[slot]       = 0;
        n = slot + 1;
        ps_count = n;
        if (!last_in && n < MAX_PROCS) begin
            return 0;
        end

        unfinished = n;
        now = 0;
        while (unfinished > 0) begin
            pick = -1;
            next_arr = NO_ARRIVAL;
            for (int i = 0; i < n; i++) begin
                if (ps_remaining[i] == 0) continue;
                if (ps_ready_at[i] <= now) begin
                    // strict compare keeps the lowest index on ties
                    if (pick < 0 || ps_prio[i] < ps_prio[pick]) pick = i;
                end else if (ps_ready_at[i] < next_arr) begin
                    next_arr = ps_ready_at[i];
                end
            end
            if (pick < 0) begin
                now = next_arr;   // idle until someone arrives
                continue;
            end
            // run the pick until it finishes or the next arrival may preempt it
            span = 64'(ps_remaining[pick]);
            if (next_arr != NO_ARRIVAL && next_arr - now < span) span = next_arr - now;
            ps_waited[pick] = 32'((ps_waited[pick] + (now - ps_ready_at[pick])) & 32'hFF_FFFF);
            now += span;
            ps_remaining[pick] = ps_remaining[pick] - 32'(span);
            ps_ready_at[pick] = now;
            if (ps_remaining[pick] == 0) begin
                ps_tat[pick] = 32'((now - ps_arrival[pick]) & 32'hFF_FFFF);
                unfinished--;
            end
        end

        sum_wait = '0;
        sum_tat  = '0;
        for (int i = 0; i < n; i++) begin
            sum_wait = sum_wait + TOT_W'(ps_waited[i]);
            sum_tat  = sum_tat + TOT_W'(ps_tat[i]);
            ps_report[i].index    = OIDX_W'(i);
            ps_report[i].waited   = TICK_W'(ps_waited[i]);
            ps_report[i].tat      = TICK_W'(ps_tat[i]);
            ps_report[i].last     = (i == n - 1);
            // totals only ride on the final result
            ps_report[i].tot_wait = (i == n - 1) ? sum_wait : '0;
            ps_report[i].tot_tat  = (i == n - 1) ? sum_tat : '0;
        end
        ps_count = 0;
        return n;
    endfunction

    // offer one process on the s_ channel and record what it should produce
    task automatic send_process(input stim_row_t row);
        int           produced;
        proc_result_t typed_res;
        // random gaps before the item
        while (!calm && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_arrival_time   <= row.arr;
        s_burst_length   <= row.burst;
        s_priority_level <= row.prio;
        s_last_process   <= row.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // accepted at this edge
        produced = accept_process(row.arr, row.burst, row.prio, row.last);
        if (row.typed) begin
            // one-process set, answer written straight into the table
            typed_res.index    = '0;
            typed_res.waited   = row.exp_wait;
            typed_res.tat      = row.exp_tat;
            typed_res.tot_wait = TOT_W'(row.exp_wait);
            typed_res.tot_tat  = TOT_W'(row.exp_tat);
            typed_res.last     = 1'b1;
            proc_results_q.push_back(typed_res);
        end else begin
            for (int i = 0; i < produced; i++) proc_results_q.push_back(ps_report[i]);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
            mismatches++;
        end
    endtask

    // result side: check at each accepting edge, then pick m_ready for the next cycle
    initial begin
        proc_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (proc_results_q.size() == 0) begin
                    $display("%0t: unexpected result for process %0d", $time, m_process_index);
                    mismatches++;
                end else begin
                    want = proc_results_q.pop_front();
                    check_field("process_index", 32'(want.index), 32'(m_process_index));
                    check_field("waiting_time", 32'(want.waited), 32'(m_waiting_time));
                    check_field("turnaround_time", 32'(want.tat), 32'(m_turnaround_time));
                    check_field("total_waiting", 32'(want.tot_wait), 32'(m_total_waiting));
                    check_field("total_turnaround", 32'(want.tot_tat),
                                32'(m_total_turnaround));
                    check_field("last_result", 32'(want.last), 32'(m_last_result));
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    // stimulus and end of run
    initial begin
        int        items;
        int        set_size;
        logic      narrow_prio;
        logic      wide_times;
        stim_row_t row;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_process(dir_rows[i]);

        // hold the sender off until the full-store set has drained
        s_valid <= 1'b0;
        @(posedge aclk);
        while (proc_results_q.size() != 0) @(posedge aclk);

        // random sets: mostly short with small times so the simulation stays quick
        items = 0;
        while (items < RANDOM_ITEMS) begin
            set_size = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
            narrow_prio = ($urandom_range(2) == 0);   // few levels, lots of ties
            for (int k = 0; k < set_size; k++) begin
                wide_times = ($urandom_range(49) == 0);
                row.arr   = wide_times ? ARR_W'($urandom_range(2000))
                                       : ARR_W'($urandom_range(40));
                row.burst = wide_times ? BURST_W'($urandom_range(2000))
                                       : BURST_W'($urandom_range(12));
                row.prio  = narrow_prio ? PRI_W'($urandom_range(3)) : PRI_W'($urandom_range(255));
                // a set of sixteen may close by the flag or by the full store
                if (k == set_size - 1) begin
                    row.last = (set_size == MAX_PROCS) ? 1'($urandom_range(1)) : 1'b1;
                end else begin
                    row.last = 1'b0;
                end
                row.typed    = 1'b0;
                row.exp_wait = '0;
                row.exp_tat  = '0;
                // long stretch with no idling on either side
                calm = (items >= 120 && items < 170);
                send_process(row);
                items++;
            end
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        while (proc_results_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && proc_results_q.size() == 0) begin
            $display("** preemptive_priority_scheduler: PASSED **");
        end else begin
            $display("** preemptive_priority_scheduler: FAILED **");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #20000000;
        $display("** preemptive_priority_scheduler: FAILED **");
        $finish;
    end

endmodule
